// ===== hdl/block_buffer_cache_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// Block buffer cache controller: assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_CONTROLLER_CORE_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTH
`define BBC_ASSERT_HOLDS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bbc: invariant violated");
`define BBC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbc: sequence violated");
`else
`define BBC_ASSERT_HOLDS(name, cond)
`define BBC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache controller package
// Sizes, codes, entry and result item layouts, address helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package bbc_pkg;
	localparam int CACHE_ENTRIES = 32;
	localparam int SECTOR_BYTES  = 512;
	localparam int PIN_BITS      = 8;
	localparam int MAX_RESULTS   = CACHE_ENTRIES + 2;
	localparam int IDX_W         = $clog2(CACHE_ENTRIES);
	localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
	localparam int RES_AW        = $clog2(MAX_RESULTS);
	localparam int RES_CW        = $clog2(MAX_RESULTS + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	localparam logic [2:0] OP_READ        = 3'd0;
	localparam logic [2:0] OP_WRITE       = 3'd1;
	localparam logic [2:0] OP_UNLOCK_BLK  = 3'd2;
	localparam logic [2:0] OP_UNLOCK_SLOT = 3'd3;
	localparam logic [2:0] OP_MARK_DIRTY  = 3'd4;
	localparam logic [2:0] OP_SYNC_ALL    = 3'd5;
	localparam logic [2:0] OP_FLUSH       = 3'd6;

	localparam logic [1:0] PIN_ADD  = 2'd1;
	localparam logic [1:0] PIN_DROP = 2'd2;

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [2:0] STAT_BAD_LEN   = 3'd2;
	localparam logic [2:0] STAT_BEYOND    = 3'd3;
	localparam logic [2:0] STAT_NO_ROOM   = 3'd4;

	localparam logic [1:0] REG_PART_START = 2'd0;
	localparam logic [1:0] REG_SPB        = 2'd1;
	localparam logic [1:0] REG_PART_SECT  = 2'd2;

	typedef struct packed {
		logic [31:0]         tag;
		logic                dirty;
		logic [PIN_BITS-1:0] pins;
	} entry_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] lba;
		logic [3:0]  cnt;
		logic [4:0]  slot;
	} item_t;

	localparam int ENTRY_W = $bits(entry_t);
	localparam int ITEM_W  = $bits(item_t);

	function automatic logic [3:0] spb_of(input logic [3:0] raw);
		logic [3:0] s;
		s = raw;
		if (s == 4'd0) s = 4'd1;
		if (s > 4'd8) s = 4'd8;
		return s;
	endfunction

	function automatic logic [31:0] lba_of(input logic [31:0] base, input logic [3:0] spb,
			input logic [31:0] tag);
		logic [35:0] prod;
		prod = 36'(tag) * 36'(spb);
		return base + prod[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== hdl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache controller: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/block_buffer_cache_controller_core.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache controller core
// Tag, dirty and pin state for a disk block cache; issues disk commands.
// ----------------------------------------------------------------------------
// channel   | signals                                   | transfer
// request   | start, busy, operation .. write_bytes     | start & !busy
// result    | result_valid, result_kind .. last         | result_valid high
// config    | psel, penable, pwrite, paddr, pwdata      | access phase, pready high
//
// A request scans the entry RAM slot by slot, a read then a check or a write per
// slot (lookup, flush, sync), then updates the entry (fill, apply read, apply
// write, finish) and emits one result item per cycle. A hit ends the scan at
// its slot; a miss that takes a slot scans every slot, and a full cache adds a
// flush scan of every slot. The single read port of the entry RAM sets the pace.
// Reset clears valid bits and counters at once; no clearing pass.
// Results cannot be stalled; busy drops in the cycle the last one is shown.
`default_nettype none
`include "block_buffer_cache_controller_core_defines.svh"
module block_buffer_cache_controller_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] block_number,
	input  wire logic [4:0]  slot_index,
	input  wire logic [1:0]  pin_action,
	input  wire logic        sync_write,
	input  wire logic [12:0] write_bytes,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [31:0]      disk_lba,
	output logic [3:0]       sector_count,
	output logic [4:0]       slot,
	output logic [2:0]       status,
	output logic             hit,
	output logic [5:0]       pinned_entries,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import bbc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEARCH_RD, ST_SEARCH_CHK, ST_FLUSH_RD, ST_FLUSH_WR, ST_FILL,
		ST_APPLY_RD, ST_APPLY_WR, ST_SYNC_RD, ST_SYNC_WR, ST_FINISH, ST_EMIT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	state_t              state_q;
	logic [31:0]         pstart_q, psect_q;
	logic [3:0]          spb_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]    used_q, pinned_q;
	logic [RES_CW-1:0]   ocnt_q;
	logic [RES_AW-1:0]   eidx_q;
	logic [IDX_W-1:0]    idx_q, slot_q;
	logic                slot_ok_q, hit_q, strobe_s1, last_s1;
	logic [2:0]          status_q;
	logic [2:0]          op_q;
	logic [31:0]         blk_q;
	logic [1:0]          pact_q;
	logic                wthru_q;

	logic                accept, cfg_wr;
	logic [3:0]          spb;
	logic                e_we;
	logic [IDX_W-1:0]    e_waddr, e_raddr;
	entry_t              e_wdata, e_rd, a_e;
	logic [ENTRY_W-1:0]  e_rdata;
	logic                push, push_ok;
	item_t               item, b_rd;
	logic [ITEM_W-1:0]   b_rdata;
	logic                cur_valid, tag_match, flush_take, sync_take, beyond;
	logic                free_ok, pin_up, pin_down, wb;
	logic [IDX_W-1:0]    free_idx;
	logic [35:0]         bound_prod;
	logic [16:0]         len_max;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign spb    = spb_of(spb_q);

	always_comb begin
		case (paddr[3:2])
			REG_PART_START: prdata = pstart_q;
			REG_SPB:        prdata = {28'd0, spb_q};
			REG_PART_SECT:  prdata = psect_q;
			default:        prdata = 32'd0;
		endcase
	end

	bbc_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	bbc_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_RESULTS)) u_result_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (ocnt_q[RES_AW-1:0]),
		.wdata (item),
		.raddr (eidx_q),
		.rdata (b_rdata)
	);

	assign e_rd = entry_t'(e_rdata);
	assign b_rd = item_t'(b_rdata);

	assign cur_valid  = valid_q[idx_q];
	assign tag_match  = cur_valid && (e_rd.tag == blk_q);
	assign flush_take = cur_valid && (e_rd.pins == '0);
	assign sync_take  = cur_valid && e_rd.dirty;
	assign bound_prod = 36'(blk_q) * 36'(spb);
	assign beyond     = bound_prod > 36'(psect_q);
	assign len_max    = 17'(spb_of(spb_q)) * 17'(SECTOR_BYTES);
	assign push_ok    = push && (ocnt_q < RES_CW'(MAX_RESULTS));

	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		a_e      = e_rd;
		pin_up   = 1'b0;
		pin_down = 1'b0;
		wb       = 1'b0;
		case (op_q)
			OP_READ: begin
				if (pact_q == PIN_ADD && e_rd.pins != PIN_MAX) begin
					a_e.pins = e_rd.pins + 1'b1;
					pin_up   = (e_rd.pins == '0);
				end
			end
			OP_WRITE: begin
				if (pact_q == PIN_DROP && e_rd.pins != '0) begin
					a_e.pins = e_rd.pins - 1'b1;
					pin_down = (e_rd.pins == PIN_BITS'(1));
				end
				if (wthru_q) begin
					wb        = 1'b1;
					a_e.dirty = 1'b0;
				end else begin
					a_e.dirty = 1'b1;
				end
			end
			OP_UNLOCK_BLK, OP_UNLOCK_SLOT: begin
				if (e_rd.pins != '0) begin
					a_e.pins = e_rd.pins - 1'b1;
					pin_down = (e_rd.pins == PIN_BITS'(1));
				end
			end
			OP_MARK_DIRTY: a_e.dirty = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		e_we    = 1'b0;
		e_waddr = idx_q;
		e_wdata = e_rd;
		e_raddr = idx_q;
		push    = 1'b0;
		item    = '{kind: KIND_WRITE, lba: lba_of(pstart_q, spb, e_rd.tag), cnt: spb,
			slot: 5'(idx_q)};
		case (state_q)
			ST_FLUSH_WR: begin
				if (flush_take) begin
					e_we          = 1'b1;
					e_wdata.dirty = 1'b0;
					push          = e_rd.dirty;
				end
			end
			ST_SYNC_WR: begin
				if (sync_take) begin
					e_we          = 1'b1;
					e_wdata.dirty = 1'b0;
					push          = 1'b1;
				end
			end
			ST_FILL: begin
				e_waddr = free_idx;
				e_wdata = '{tag: blk_q, dirty: 1'b0, pins: '0};
				item    = '{kind: KIND_READ, lba: lba_of(pstart_q, spb, blk_q), cnt: spb,
					slot: 5'(free_idx)};
				if (!beyond && free_ok) begin
					e_we = 1'b1;
					push = 1'b1;
				end
			end
			ST_APPLY_RD: e_raddr = slot_q;
			ST_APPLY_WR: begin
				e_we      = 1'b1;
				e_waddr   = slot_q;
				e_wdata   = a_e;
				item.slot = 5'(slot_q);
				push      = wb;
			end
			ST_FINISH: begin
				push = 1'b1;
				item = '{kind: KIND_STATUS, lba: 32'd0, cnt: 4'd0,
					slot: (status_q == STAT_OK && slot_ok_q) ? 5'(slot_q) : 5'd0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			blk_q   <= block_number;
			pact_q  <= pin_action;
			wthru_q <= sync_write;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pstart_q  <= 32'd0;
			spb_q     <= 4'd1;
			psect_q   <= 32'd0;
			valid_q   <= '0;
			used_q    <= '0;
			pinned_q  <= '0;
			ocnt_q    <= '0;
			eidx_q    <= '0;
			idx_q     <= '0;
			slot_q    <= '0;
			slot_ok_q <= 1'b0;
			hit_q     <= 1'b0;
			status_q  <= STAT_OK;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			strobe_s1 <= (state_q == ST_EMIT);
			last_s1   <= (state_q == ST_EMIT) && (RES_CW'(eidx_q) == ocnt_q - 1'b1);
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_PART_START: pstart_q <= pwdata;
					REG_SPB:        spb_q    <= pwdata[3:0];
					REG_PART_SECT:  psect_q  <= pwdata;
					default: ;
				endcase
			end
			if (push_ok) begin
				ocnt_q <= ocnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ocnt_q    <= '0;
						status_q  <= STAT_OK;
						hit_q     <= 1'b0;
						slot_ok_q <= 1'b0;
						idx_q     <= '0;
						case (operation)
							OP_READ, OP_WRITE: begin
								if (operation == OP_WRITE && 17'(write_bytes) > len_max) begin
									status_q <= STAT_BAD_LEN;
									state_q  <= ST_FINISH;
								end else begin
									state_q <= ST_SEARCH_RD;
								end
							end
							OP_UNLOCK_BLK, OP_MARK_DIRTY: state_q <= ST_SEARCH_RD;
							OP_UNLOCK_SLOT: begin
								if (int'(slot_index) < CACHE_ENTRIES
										&& valid_q[IDX_W'(slot_index)]) begin
									slot_q    <= IDX_W'(slot_index);
									slot_ok_q <= 1'b1;
									state_q   <= ST_APPLY_RD;
								end else begin
									status_q <= STAT_NOT_FOUND;
									state_q  <= ST_FINISH;
								end
							end
							OP_SYNC_ALL: state_q <= ST_SYNC_RD;
							OP_FLUSH:    state_q <= ST_FLUSH_RD;
							default:     state_q <= ST_FINISH;
						endcase
					end
				end
				ST_SEARCH_RD: state_q <= ST_SEARCH_CHK;
				ST_SEARCH_CHK: begin
					if (tag_match) begin
						slot_q    <= idx_q;
						slot_ok_q <= 1'b1;
						hit_q     <= 1'b1;
						state_q   <= ST_APPLY_RD;
					end else if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						if (op_q == OP_READ || op_q == OP_WRITE) begin
							state_q <= (used_q >= CNT_W'(CACHE_ENTRIES)) ? ST_FLUSH_RD : ST_FILL;
						end else begin
							status_q <= STAT_NOT_FOUND;
							state_q  <= ST_FINISH;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SEARCH_RD;
					end
				end
				ST_FLUSH_RD: state_q <= ST_FLUSH_WR;
				ST_FLUSH_WR: begin
					if (flush_take) begin
						valid_q[idx_q] <= 1'b0;
						if (used_q != '0) used_q <= used_q - 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= (op_q == OP_FLUSH) ? ST_FINISH : ST_FILL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FLUSH_RD;
					end
				end
				ST_FILL: begin
					if (beyond) begin
						status_q <= STAT_BEYOND;
						state_q  <= ST_FINISH;
					end else if (!free_ok) begin
						status_q <= STAT_NO_ROOM;
						state_q  <= ST_FINISH;
					end else begin
						valid_q[free_idx] <= 1'b1;
						used_q            <= used_q + 1'b1;
						slot_q            <= free_idx;
						slot_ok_q         <= 1'b1;
						state_q           <= ST_APPLY_RD;
					end
				end
				ST_APPLY_RD: state_q <= ST_APPLY_WR;
				ST_APPLY_WR: begin
					if (pin_up) begin
						pinned_q <= pinned_q + 1'b1;
					end else if (pin_down && pinned_q != '0) begin
						pinned_q <= pinned_q - 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_SYNC_RD: state_q <= ST_SYNC_WR;
				ST_SYNC_WR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SYNC_RD;
					end
				end
				ST_FINISH: begin
					eidx_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					eidx_q <= eidx_q + 1'b1;
					if (RES_CW'(eidx_q) == ocnt_q - 1'b1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid   = strobe_s1;
	assign result_kind    = b_rd.kind;
	assign disk_lba       = b_rd.lba;
	assign sector_count   = b_rd.cnt;
	assign slot           = b_rd.slot;
	assign status         = status_q;
	assign hit            = hit_q;
	assign pinned_entries = 6'(pinned_q);
	assign last           = last_s1;

	`BBC_ASSERT_HOLDS(a_used_matches_valid, used_q == CNT_W'($countones(valid_q)))
	`BBC_ASSERT_HOLDS(a_pinned_le_used, pinned_q <= used_q)
	`BBC_ASSERT_HOLDS(a_ocnt_bound, ocnt_q <= RES_CW'(MAX_RESULTS))
	`BBC_ASSERT_NEXT(a_last_ends_burst, strobe_s1 && last_s1, !strobe_s1)
endmodule
`default_nettype wire

// ===== test/block_buffer_cache_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache controller core testbench
// Drives cache requests through the command port and reconfigures the
// partition over APB between phases. Every request is run through a local
// model of the slot tags, dirty bits and pin counts, and each transfer on
// the result strobe is checked field by field against the expected items.
// Covers hits, misses, writebacks, flush and sync, pin release at zero, a
// cache full of pinned entries, the partition bound and a result list overflow.
// ----------------------------------------------------------------------------
`default_nettype none
module block_buffer_cache_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bbc_pkg::*;

	localparam logic [2:0] OP_NONE  = 3'd7;
	localparam logic [1:0] PIN_NONE = 2'd0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] lba;
		logic [3:0]  cnt;
		logic [4:0]  slot;
		logic [2:0]  status;
		logic        hit;
		logic [5:0]  pinned;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] blk;
		logic [4:0]  sidx;
		logic [1:0]  pact;
		logic        wthru;
		logic [12:0] dlen;
		logic [2:0]  status;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [31:0] block_number = '0;
	logic [4:0]  slot_index = '0;
	logic [1:0]  pin_action = '0;
	logic        sync_write = 1'b0;
	logic [12:0] write_bytes = '0;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [31:0] disk_lba;
	logic [3:0]  sector_count;
	logic [4:0]  slot;
	logic [2:0]  status;
	logic        hit;
	logic [5:0]  pinned_entries;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	block_buffer_cache_controller_core dut (.*);

	// cache model
	logic [31:0]         part_start;
	logic [3:0]          spb_raw;
	logic [31:0]         part_sectors;
	logic                slot_valid [CACHE_ENTRIES];
	logic [31:0]         slot_tag [CACHE_ENTRIES];
	logic                slot_dirty [CACHE_ENTRIES];
	logic [PIN_BITS-1:0] slot_pins [CACHE_ENTRIES];
	int                  used_slots;
	int                  pinned_slots;
	result_t             issued_cmds[$];
	result_t             awaited_results[$];
	logic [2:0]          last_status;

	int errors = 0;
	int requests = 0;
	int checked = 0;
	int disk_cmds = 0;
	bit calm = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("block_buffer_cache_controller_core: mismatch");
		$finish;
	end

	function automatic logic [3:0] eff_spb();
		logic [3:0] s;
		s = spb_raw;
		if (s == 4'd0) s = 4'd1;
		if (s > 4'd8) s = 4'd8;
		return s;
	endfunction

	function automatic logic [31:0] sector_of(input logic [31:0] tag);
		return part_start + tag * {28'd0, eff_spb()};
	endfunction

	function automatic void push_cmd(input logic [1:0] kind, input logic [31:0] lba,
			input logic [3:0] cnt, input int idx);
		result_t r;
		if (issued_cmds.size() >= MAX_RESULTS) return;
		r = '0;
		r.kind = kind;
		r.lba = lba;
		r.cnt = cnt;
		r.slot = idx[4:0];
		issued_cmds.push_back(r);
	endfunction

	function automatic void flush_dirty_slot(input int i);
		push_cmd(KIND_WRITE, sector_of(slot_tag[i]), eff_spb(), i);
		slot_dirty[i] = 1'b0;
	endfunction

	function automatic void drop_unpinned();
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (slot_valid[i] && slot_pins[i] == 0) begin
				if (slot_dirty[i]) flush_dirty_slot(i);
				slot_valid[i] = 1'b0;
				slot_dirty[i] = 1'b0;
				if (used_slots > 0) used_slots--;
			end
	endfunction

	function automatic int lookup(input logic [31:0] tag);
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (slot_valid[i] && slot_tag[i] == tag) return i;
		return -1;
	endfunction

	function automatic logic [2:0] allocate(input logic [31:0] tag, output int idx);
		idx = -1;
		if (used_slots >= CACHE_ENTRIES) drop_unpinned();
		if ({32'd0, tag} * 64'(eff_spb()) > {32'd0, part_sectors}) return STAT_BEYOND;
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (!slot_valid[i]) begin
				slot_valid[i] = 1'b1;
				slot_tag[i] = tag;
				slot_dirty[i] = 1'b0;
				slot_pins[i] = '0;
				used_slots++;
				push_cmd(KIND_READ, sector_of(tag), eff_spb(), i);
				idx = i;
				return STAT_OK;
			end
		return STAT_NO_ROOM;
	endfunction

	function automatic void add_pin(input int i);
		if (slot_pins[i] != PIN_MAX) begin
			slot_pins[i]++;
			if (slot_pins[i] == 1) pinned_slots++;
		end
	endfunction

	function automatic void drop_pin(input int i);
		if (slot_pins[i] != 0) begin
			slot_pins[i]--;
			if (slot_pins[i] == 0 && pinned_slots > 0) pinned_slots--;
		end
	endfunction

	function automatic void cache_request(input logic [2:0] op, input logic [31:0] blk,
			input logic [4:0] sidx, input logic [1:0] pact, input logic wthru,
			input logic [12:0] dlen);
		logic [2:0] st;
		logic       h;
		int         idx;
		st = STAT_OK;
		h = 1'b0;
		idx = -1;
		issued_cmds.delete();
		case (op)
			OP_READ, OP_WRITE: begin
				if (op == OP_WRITE && 32'(dlen) > 32'(eff_spb()) * SECTOR_BYTES) begin
					st = STAT_BAD_LEN;
				end else begin
					idx = lookup(blk);
					if (idx >= 0) h = 1'b1;
					else st = allocate(blk, idx);
					if (st == STAT_OK && idx >= 0) begin
						if (op == OP_READ) begin
							if (pact == PIN_ADD) add_pin(idx);
						end else begin
							if (pact == PIN_DROP) drop_pin(idx);
							if (wthru) flush_dirty_slot(idx);
							else slot_dirty[idx] = 1'b1;
						end
					end
				end
			end
			OP_UNLOCK_BLK, OP_MARK_DIRTY: begin
				idx = lookup(blk);
				if (idx < 0) begin
					st = STAT_NOT_FOUND;
				end else begin
					h = 1'b1;
					if (op == OP_UNLOCK_BLK) drop_pin(idx);
					else slot_dirty[idx] = 1'b1;
				end
			end
			OP_UNLOCK_SLOT: begin
				if (slot_valid[sidx]) begin
					idx = sidx;
					drop_pin(idx);
				end else begin
					st = STAT_NOT_FOUND;
				end
			end
			OP_SYNC_ALL: begin
				for (int k = 0; k < CACHE_ENTRIES; k++)
					if (slot_valid[k] && slot_dirty[k]) flush_dirty_slot(k);
			end
			OP_FLUSH: drop_unpinned();
			default: ;
		endcase
		if (st != STAT_OK) idx = -1;
		push_cmd(KIND_STATUS, '0, '0, idx >= 0 ? idx : 0);
		foreach (issued_cmds[k]) begin
			issued_cmds[k].status = st;
			issued_cmds[k].hit = h;
			issued_cmds[k].pinned = pinned_slots[5:0];
			issued_cmds[k].last = (k == issued_cmds.size() - 1);
			awaited_results.push_back(issued_cmds[k]);
		end
		disk_cmds += issued_cmds.size() - 1;
		last_status = st;
	endfunction

	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d", result_kind, slot);
				errors++;
			end else begin
				e = awaited_results.pop_front();
				checked++;
				if (result_kind !== e.kind) begin
					$error("result_kind: expected %0d, got %0d", e.kind, result_kind);
					errors++;
				end
				if (disk_lba !== e.lba) begin
					$error("disk_lba: expected %h, got %h", e.lba, disk_lba);
					errors++;
				end
				if (sector_count !== e.cnt) begin
					$error("sector_count: expected %0d, got %0d", e.cnt, sector_count);
					errors++;
				end
				if (slot !== e.slot) begin
					$error("slot: expected %0d, got %0d", e.slot, slot);
					errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit);
					errors++;
				end
				if (pinned_entries !== e.pinned) begin
					$error("pinned_entries: expected %0d, got %0d", e.pinned, pinned_entries);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	task automatic send(input logic [2:0] op, input logic [31:0] blk, input logic [4:0] sidx,
			input logic [1:0] pact, input logic wthru, input logic [12:0] dlen);
		operation <= op;
		block_number <= blk;
		slot_index <= sidx;
		pin_action <= pact;
		sync_write <= wthru;
		write_bytes <= dlen;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		cache_request(op, blk, sidx, pact, wthru, dlen);
		requests++;
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PART_START: part_start = value;
			REG_SPB:        spb_raw = value[3:0];
			default:        part_sectors = value;
		endcase
	endtask

	task automatic configure(input logic [31:0] base, input logic [31:0] spb,
			input logic [31:0] limit);
		drain();
		reg_write(REG_PART_START, base);
		reg_write(REG_SPB, spb);
		reg_write(REG_PART_SECT, limit);
		@(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		int          pick;
		logic [2:0]  op;
		logic [31:0] blk;
		logic [12:0] dl;
		for (int n = 0; n < count; n++) begin
			calm = (n >= 40 && n < 100);
			if (n == count / 2) drain();
			pick = $urandom_range(99);
			if (pick < 30) op = OP_READ;
			else if (pick < 60) op = OP_WRITE;
			else if (pick < 70) op = OP_UNLOCK_BLK;
			else if (pick < 79) op = OP_UNLOCK_SLOT;
			else if (pick < 87) op = OP_MARK_DIRTY;
			else if (pick < 92) op = OP_SYNC_ALL;
			else if (pick < 97) op = OP_FLUSH;
			else op = OP_NONE;
			blk = ($urandom_range(99) < 85) ? $urandom_range(0, 45) : $urandom;
			dl = ($urandom_range(99) < 85)
				? 13'($urandom_range(0, 32'(eff_spb()) * SECTOR_BYTES))
				: 13'($urandom_range(0, 8191));
			maybe_idle();
			send(op, blk, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), dl);
		end
		calm = 0;
	endtask

	initial begin
		request_row_t plan [21];
		part_start = '0;
		spb_raw = 4'd1;
		part_sectors = '0;
		used_slots = 0;
		pinned_slots = 0;
		last_status = STAT_OK;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_tag[i] = '0;
			slot_dirty[i] = 1'b0;
			slot_pins[i] = '0;
		end
		plan = '{
			'{OP_READ,        32'd0,     5'd0,  PIN_ADD,  1'b0, 13'd0,    STAT_OK},
			'{OP_READ,        32'd0,     5'd0,  PIN_ADD,  1'b0, 13'd0,    STAT_OK},
			'{OP_UNLOCK_BLK,  32'd0,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_UNLOCK_SLOT, 32'd0,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_UNLOCK_SLOT, 32'd0,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_UNLOCK_SLOT, 32'd0,     5'd31, PIN_NONE, 1'b0, 13'd0,    STAT_NOT_FOUND},
			'{OP_UNLOCK_BLK,  32'd999,   5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_NOT_FOUND},
			'{OP_MARK_DIRTY,  32'd0,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_MARK_DIRTY,  32'd5,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_NOT_FOUND},
			'{OP_WRITE,       32'd1,     5'd0,  PIN_NONE, 1'b0, 13'd1025, STAT_BAD_LEN},
			'{OP_WRITE,       32'd1,     5'd0,  PIN_NONE, 1'b1, 13'd1024, STAT_OK},
			'{OP_WRITE,       32'd2,     5'd0,  PIN_ADD,  1'b0, 13'd0,    STAT_OK},
			'{OP_READ,        32'd2,     5'd0,  PIN_DROP, 1'b0, 13'd0,    STAT_OK},
			'{OP_READ,        32'd33,    5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_BEYOND},
			'{OP_READ,        32'd32,    5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_READ,        '1,        5'd0,  2'd3,     1'b0, 13'd0,    STAT_BEYOND},
			'{OP_SYNC_ALL,    32'd0,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_FLUSH,       32'd0,     5'd0,  PIN_NONE, 1'b0, 13'd0,    STAT_OK},
			'{OP_NONE,        '1,        5'd31, 2'd3,     1'b1, 13'd8191, STAT_OK},
			'{OP_WRITE,       32'd3,     5'd0,  PIN_NONE, 1'b0, 13'd8191, STAT_BAD_LEN},
			'{OP_WRITE,       32'd0,     5'd0,  PIN_DROP, 1'b0, 13'd512,  STAT_OK}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(32'd1000, 32'd2, 32'd64);
		foreach (plan[i]) begin
			maybe_idle();
			send(plan[i].op, plan[i].blk, plan[i].sidx, plan[i].pact, plan[i].wthru,
				plan[i].dlen);
			if (last_status !== plan[i].status) begin
				$error("status: expected %0d, got %0d", plan[i].status, last_status);
				errors++;
			end
		end

		configure(32'hFFFF_FFF0, 32'd8, '1);
		send(OP_FLUSH, '0, '0, PIN_NONE, 1'b0, '0);
		for (int i = 0; i < 34; i++) begin
			maybe_idle();
			send(OP_READ, 32'd1000 + i, '0, PIN_ADD, 1'b0, '0);
		end
		for (int i = 0; i < CACHE_ENTRIES; i++)
			send(OP_UNLOCK_SLOT, '0, 5'(i), PIN_NONE, 1'b0, '0);
		// fill with dirty entries, then overflow the result list
		send(OP_FLUSH, '0, '0, PIN_NONE, 1'b0, '0);
		for (int i = 0; i < CACHE_ENTRIES; i++)
			send(OP_WRITE, 32'd2000 + i, '0, PIN_NONE, 1'b0, 13'd4096);
		send(OP_WRITE, 32'h1000_0000, '0, PIN_NONE, 1'b1, 13'd4096);

		configure('0, '0, '0);
		send(OP_READ, 32'd0, '0, PIN_NONE, 1'b0, '0);
		send(OP_READ, 32'd1, '0, PIN_NONE, 1'b0, '0);
		send(OP_WRITE, 32'd0, '0, PIN_NONE, 1'b1, 13'd512);
		send(OP_SYNC_ALL, '0, '0, PIN_NONE, 1'b0, '0);

		configure($urandom, 32'd15, 32'($urandom_range(100, 400)));
		random_traffic(72);
		configure($urandom, 32'($urandom_range(1, 7)), '1);
		random_traffic(72);

		drain();
		repeat (200) @(posedge clk);
		$display("ran %0d requests over five partition settings, %0d disk commands,",
			requests, disk_cmds);
		$display("%0d results checked; hits, misses, flush and sync writebacks,", checked);
		$display("a full pinned cache, the partition bound and result overflow");
		if (errors == 0 && awaited_results.size() == 0)
			$display("block_buffer_cache_controller_core: match");
		else
			$display("block_buffer_cache_controller_core: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
